FILE: src/split_register_lru_allocator_macros.svh
// Assertion macros for the allocator's checker.
`ifndef SPLIT_REGISTER_LRU_ALLOCATOR_MACROS_SVH
`define SPLIT_REGISTER_LRU_ALLOCATOR_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SRA_CHECK(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("allocator check failed");

// Check that a cause at one edge is followed by an effect at the next.
`define SRA_CHECK_NEXT(name, cause, effect) \
  name: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("allocator sequence check failed");

`endif

FILE: src/sra_pkg.sv
// Constants, types and code helpers for the split register LRU allocator.
package sra_pkg;

  localparam int GROUPS    = 4;
  localparam int TAG_BITS  = 16;
  localparam int TIME_BITS = 32;
  localparam int PARTS     = 3;

  localparam int GRP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int TAG_W = (TAG_BITS < 16) ? TAG_BITS : 16;

  localparam logic [1:0] P_WORD = 2'd0;
  localparam logic [1:0] P_HIGH = 2'd1;
  localparam logic [1:0] P_LOW  = 2'd2;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_BIND    = 2'd1,
    REQ_REL     = 2'd2,
    REQ_REL_ALL = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_PLACE,
    ST_RESP
  } state_t;

  typedef logic [TAG_W-1:0]     tag_t;
  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [GRP_W-1:0]     grp_t;

  typedef struct packed {
    tag_t  [PARTS-1:0] tags;
    time_t [PARTS-1:0] times;
  } row_t;

  typedef struct packed {
    logic             clr_all;
    grp_t             row;
    logic [PARTS-1:0] set;
    logic [PARTS-1:0] clr;
  } wr_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] hit_part;
    logic       free;
    logic       take;
    time_t      newest;
    logic [1:0] byte_off;
  } scan_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] code;
    logic       load;
  } resp_t;

  // code / 3 for a 4-bit code: multiply by 11, keep bits 7 down to 5
  function automatic logic [3:0] code_grp(input logic [3:0] code);
    logic [7:0] p;
    p = {4'b0, code} * 8'd11;
    return {1'b0, p[7:5]};
  endfunction

  function automatic logic [1:0] code_part(input logic [3:0] code);
    logic [3:0] g;
    logic [3:0] g3;
    logic [3:0] r;
    g  = code_grp(code);
    g3 = (g << 1) + g;
    r  = code - g3;
    return r[1:0];
  endfunction

  function automatic logic [3:0] code_of(input grp_t g, input logic [1:0] p);
    logic [5:0] c;
    c = (6'(g) << 1) + 6'(g) + 6'(p);
    return c[3:0];
  endfunction

endpackage

FILE: src/split_register_lru_allocator.sv
// Top level of the split register LRU allocator.
//
// Input channel: in_valid / in_stall carries one request (req_type, var_tag,
// is_byte, target_reg). A request is taken at a rising edge with in_valid
// high and in_stall low; in_stall stays high while a request is worked on.
// Output channel: out_valid / out_stall carries one result per request
// (out_reg, must_load), held in an output register until taken.
// Bind, release and release-all pass through the execute and respond states
// before the next acceptance. Allocate walks the groups through one compare
// unit, one group per cycle, and stops at a hit, at a free group or at the
// last group; after a free or last group it places the chosen group first.
// A new request is accepted while a result still waits in the output
// register; the block then holds its next result until the register frees.
// Reset empties all parts, zeroes the use clock and drops out_valid; no
// clearing pass is needed afterwards.
module split_register_lru_allocator import sra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] var_tag,
  input  logic        is_byte,
  input  logic [3:0]  target_reg,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_reg,
  output logic        must_load
);

  grp_t  rd_row;
  row_t  rd_data;
  wr_t   wr;
  tag_t  wr_tag;
  time_t wr_time;
  resp_t resp;
  logic  out_free;

  assign out_free = !out_valid || !out_stall;

  sra_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_row  (rd_row),
    .rd_data (rd_data),
    .wr      (wr),
    .wr_tag  (wr_tag),
    .wr_time (wr_time)
  );

  sra_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .var_tag    (var_tag),
    .is_byte    (is_byte),
    .target_reg (target_reg),
    .out_free   (out_free),
    .resp       (resp),
    .rd_row     (rd_row),
    .rd_data    (rd_data),
    .wr         (wr),
    .wr_tag     (wr_tag),
    .wr_time    (wr_time)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp.valid) begin
      out_reg   <= resp.code;
      must_load <= resp.load;
    end
  end

endmodule

FILE: src/sra_regfile.sv
// Tag and last-use time storage, one row per register group.
module sra_regfile import sra_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  grp_t  rd_row,
  output row_t  rd_data,
  input  wr_t   wr,
  input  tag_t  wr_tag,
  input  time_t wr_time
);

  row_t rows [GROUPS];

  always_ff @(posedge clk) begin
    if (rst || wr.clr_all) begin
      for (int g = 0; g < GROUPS; g++) begin
        rows[g] <= '0;
      end
    end else begin
      for (int p = 0; p < PARTS; p++) begin
        if (wr.set[p]) begin
          rows[wr.row].tags[p]  <= wr_tag;
          rows[wr.row].times[p] <= wr_time;
        end else if (wr.clr[p]) begin
          rows[wr.row].tags[p]  <= '0;
          rows[wr.row].times[p] <= '0;
        end
      end
    end
  end

  assign rd_data = rows[rd_row];

endmodule

FILE: src/sra_scan.sv
// Shared compare unit: evaluates one register group against the request.
module sra_scan import sra_pkg::*; (
  input  row_t  row,
  input  tag_t  tag,
  input  logic  byte_sz,
  input  time_t best,
  output scan_t res
);

  time_t tw;
  time_t th;
  time_t tl;
  time_t newest;

  always_comb begin
    tw = row.times[P_WORD];
    th = row.times[P_HIGH];
    tl = row.times[P_LOW];
    newest = tw;
    if (th >= newest) begin
      newest = th;
    end
    if (tl >= newest) begin
      newest = tl;
    end

    res = '0;
    if (!byte_sz) begin
      res.hit      = (tag != '0) && (row.tags[P_WORD] == tag);
      res.hit_part = P_WORD;
      res.free     = (tw == '0) && (th == '0) && (tl == '0);
    end else begin
      // low part is checked before high
      if (row.tags[P_LOW] == tag) begin
        res.hit      = 1'b1;
        res.hit_part = P_LOW;
      end else if (row.tags[P_HIGH] == tag) begin
        res.hit      = 1'b1;
        res.hit_part = P_HIGH;
      end
      res.free = ((tl == '0) || (th == '0)) && (tw == '0);
    end
    res.take     = (best >= newest);
    res.newest   = newest;
    res.byte_off = (tl > th) ? P_HIGH : P_LOW;
  end

endmodule

FILE: src/sra_seq.sv
// Request sequencer: walks the groups one per cycle through the compare unit.
module sra_seq import sra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [15:0] var_tag,
  input  logic       is_byte,
  input  logic [3:0] target_reg,
  input  logic       out_free,
  output resp_t      resp,
  output grp_t       rd_row,
  input  row_t       rd_data,
  output wr_t        wr,
  output tag_t       wr_tag,
  output time_t      wr_time
);

  state_t state;
  state_t state_next;

  req_t       q_req;
  tag_t       q_tag;
  logic       q_byte;
  logic [3:0] q_code;

  time_t use_clock;
  time_t clock_inc;
  grp_t  grp;
  grp_t  seg;
  time_t best;

  logic [3:0] res_code;
  logic       res_load;
  logic       res_we;
  logic [3:0] res_code_next;
  logic       res_load_next;

  logic [3:0] code_g;
  logic [1:0] code_p;
  logic       in_range;
  grp_t       code_row;
  logic       eff_byte;
  logic       last;
  scan_t      sc;

  assign clock_inc = use_clock + TIME_BITS'(1);
  assign code_g    = code_grp(q_code);
  assign code_p    = code_part(q_code);
  assign in_range  = {1'b0, code_g} < 5'(GROUPS);
  assign code_row  = code_g[GRP_W-1:0];
  assign eff_byte  = (q_tag == '0) ? (code_p != P_WORD) : q_byte;
  assign last      = (grp == GRP_W'(GROUPS - 1));
  assign rd_row    = (state == ST_PLACE) ? seg : grp;

  sra_scan u_scan (
    .row     (rd_data),
    .tag     (q_tag),
    .byte_sz (eff_byte),
    .best    (best),
    .res     (sc)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = (q_req == REQ_ALLOC) ? ST_SCAN : ST_RESP;
      end
      ST_SCAN: begin
        if (sc.hit) begin
          state_next = ST_RESP;
        end else if (sc.free || last) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != ST_IDLE);
    wr            = '0;
    wr_tag        = q_tag;
    wr_time       = (state == ST_EXEC) ? clock_inc : use_clock;
    res_we        = 1'b0;
    res_code_next = q_code;
    res_load_next = 1'b0;
    resp.valid    = (state == ST_RESP) && out_free;
    resp.code     = res_code;
    resp.load     = res_load;
    case (state)
      ST_EXEC: begin
        wr.row = code_row;
        case (q_req)
          REQ_BIND: begin
            wr.set[code_p] = in_range;
            res_we         = 1'b1;
            res_load_next  = 1'b1;
          end
          REQ_REL: begin
            wr.clr[code_p] = in_range;
            res_we         = 1'b1;
          end
          REQ_REL_ALL: begin
            wr.clr_all    = 1'b1;
            res_we        = 1'b1;
            res_code_next = '0;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        wr.row = grp;
        if (sc.hit) begin
          // refresh the part that already holds the variable
          wr.set[sc.hit_part] = 1'b1;
          res_we              = 1'b1;
          res_code_next       = code_of(grp, sc.hit_part);
        end
      end
      ST_PLACE: begin
        wr.row        = seg;
        res_we        = 1'b1;
        res_load_next = 1'b1;
        if (!eff_byte) begin
          wr.set[P_WORD] = 1'b1;
          wr.clr[P_HIGH] = 1'b1;
          wr.clr[P_LOW]  = 1'b1;
          res_code_next  = code_of(seg, P_WORD);
        end else begin
          wr.set[sc.byte_off] = 1'b1;
          wr.clr[P_WORD]      = 1'b1;
          res_code_next       = code_of(seg, sc.byte_off);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_clock <= '0;
      grp       <= '0;
      seg       <= '0;
    end else begin
      case (state)
        ST_EXEC: begin
          if (q_req == REQ_ALLOC || q_req == REQ_BIND) begin
            use_clock <= clock_inc;
          end
          grp <= '0;
          seg <= '0;
        end
        ST_SCAN: begin
          if (!sc.hit) begin
            if (sc.free) begin
              seg <= grp;
            end else begin
              if (sc.take) seg <= grp;
              if (!last) grp <= grp + GRP_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      q_req  <= req_t'(req_type);
      q_tag  <= var_tag[TAG_W-1:0];
      q_byte <= is_byte;
      q_code <= target_reg;
    end
    if (state == ST_EXEC) begin
      best <= clock_inc;
    end else if (state == ST_SCAN && !sc.hit && !sc.free && sc.take) begin
      best <= sc.newest;
    end
    if (res_we) begin
      res_code <= res_code_next;
      res_load <= res_load_next;
    end
  end

endmodule

FILE: src/sra_checker.sv
// Port-level checks for the split register LRU allocator, bound to the top.
`include "split_register_lru_allocator_macros.svh"

module sra_checker import sra_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  req_type,
  input logic [3:0]  target_reg,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_reg,
  input logic        must_load
);

  // a stalled result stays offered
  `SRA_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // the block works on one request at a time
  `SRA_CHECK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // release all answers register 0 with no load
  `SRA_CHECK(a_rel_all_resp,
    (in_valid && !in_stall && req_type == REQ_REL_ALL && !out_valid) |=>
      ##2 (out_valid && out_reg == 4'd0 && !must_load))

  // release one echoes the named register with no load
  `SRA_CHECK(a_rel_one_resp,
    (in_valid && !in_stall && req_type == REQ_REL && !out_valid) |=>
      ##2 (out_valid && out_reg == $past(target_reg, 3) && !must_load))

endmodule

bind split_register_lru_allocator sra_checker u_sra_checker (.*);

FILE: tb/tb_split_register_lru_allocator.sv
// Self-checking testbench for the split register LRU allocator.
`timescale 1ns / 1ps

module tb_split_register_lru_allocator;
  import sra_pkg::*;

  localparam int SLOTS       = GROUPS * PARTS;
  localparam int RANDOM_REQS = 2000;
  localparam int IDLE_LIMIT  = 3000;

  typedef struct packed {
    logic [3:0] reg_code;
    logic       load;
  } grant_t;

  typedef struct {
    req_t       kind;
    tag_t       tag;
    logic       byte_sz;
    logic [3:0] code;
    bit         drain_first;
  } alloc_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = REQ_ALLOC;
  logic [15:0] var_tag = '0;
  logic        is_byte = 1'b0;
  logic [3:0]  target_reg = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_reg;
  logic        must_load;

  // predictor state
  tag_t  slot_tag[SLOTS];
  time_t slot_stamp[SLOTS];
  time_t lru_clock;

  alloc_req_t req_queue[$];
  grant_t     pending_grants[$];

  int  mismatches    = 0;
  int  reqs_sent     = 0;
  int  reqs_accepted = 0;
  int  grants_seen   = 0;
  int  hold_left     = 0;
  bit  hold_done     = 0;
  bit  req_taken     = 0;

  split_register_lru_allocator dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .var_tag    (var_tag),
    .is_byte    (is_byte),
    .target_reg (target_reg),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_reg    (out_reg),
    .must_load  (must_load)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic time_t newest_stamp(input int grp);
    time_t m;
    m = slot_stamp[grp*PARTS + P_WORD];
    if (slot_stamp[grp*PARTS + P_HIGH] > m) m = slot_stamp[grp*PARTS + P_HIGH];
    if (slot_stamp[grp*PARTS + P_LOW] > m) m = slot_stamp[grp*PARTS + P_LOW];
    return m;
  endfunction

  function automatic grant_t predict_grant(input req_t kind, input tag_t tag,
                                           input logic byte_in, input logic [3:0] code);
    logic       word_sz;
    bit         stop;
    int         grp;
    int         base;
    int         pick;
    logic [1:0] part;
    time_t      best;
    time_t      newest;
    grant_t     g;
    stop = 0;
    pick = 0;
    g = '0;
    if (kind == REQ_REL_ALL) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_tag[s] = '0;
        slot_stamp[s] = '0;
      end
      return g;
    end
    if (kind == REQ_REL) begin
      if (code < SLOTS) begin
        slot_tag[code] = '0;
        slot_stamp[code] = '0;
      end
      g.reg_code = code;
      return g;
    end
    lru_clock = lru_clock + 1'b1;
    if (kind == REQ_BIND) begin
      if (code < SLOTS) begin
        slot_tag[code] = tag;
        slot_stamp[code] = lru_clock;
      end
      g.reg_code = code;
      g.load = 1'b1;
      return g;
    end
    // an empty tag takes its size from the part named by the code
    word_sz = (tag == 0) ? ((code % PARTS) == 0) : !byte_in;
    best = lru_clock;
    for (grp = 0; grp < GROUPS && !stop; grp++) begin
      base = grp * PARTS;
      if (word_sz) begin
        if (tag != 0 && slot_tag[base + P_WORD] == tag) begin
          slot_stamp[base + P_WORD] = lru_clock;
          g.reg_code = 4'(base + P_WORD);
          return g;
        end
        if (slot_stamp[base + P_WORD] == 0 && slot_stamp[base + P_LOW] == 0 &&
            slot_stamp[base + P_HIGH] == 0) begin
          pick = grp;
          stop = 1;
        end
      end else begin
        if (slot_tag[base + P_LOW] == tag) begin
          slot_stamp[base + P_LOW] = lru_clock;
          g.reg_code = 4'(base + P_LOW);
          return g;
        end
        if (slot_tag[base + P_HIGH] == tag) begin
          slot_stamp[base + P_HIGH] = lru_clock;
          g.reg_code = 4'(base + P_HIGH);
          return g;
        end
        if ((slot_stamp[base + P_LOW] == 0 || slot_stamp[base + P_HIGH] == 0) &&
            slot_stamp[base + P_WORD] == 0) begin
          pick = grp;
          stop = 1;
        end
      end
      if (!stop) begin
        // later group wins a tie
        newest = newest_stamp(grp);
        if (best >= newest) begin
          pick = grp;
          best = newest;
        end
      end
    end
    base = pick * PARTS;
    if (word_sz) begin
      part = P_WORD;
      slot_tag[base + P_LOW] = '0;
      slot_stamp[base + P_LOW] = '0;
      slot_tag[base + P_HIGH] = '0;
      slot_stamp[base + P_HIGH] = '0;
    end else begin
      part = (slot_stamp[base + P_LOW] > slot_stamp[base + P_HIGH]) ? P_HIGH : P_LOW;
      slot_tag[base + P_WORD] = '0;
      slot_stamp[base + P_WORD] = '0;
    end
    slot_tag[base + part] = tag;
    slot_stamp[base + part] = lru_clock;
    g.reg_code = 4'(base + part);
    g.load = 1'b1;
    return g;
  endfunction

  task automatic add_req(input req_t kind, input tag_t tag, input logic byte_sz,
                         input logic [3:0] code, input bit drain_first);
    alloc_req_t r;
    r.kind = kind;
    r.tag = tag;
    r.byte_sz = byte_sz;
    r.code = code;
    r.drain_first = drain_first;
    req_queue.push_back(r);
  endtask

  // driver: advance to the next request once the current one is taken
  always @(negedge clk) begin
    alloc_req_t nxt;
    bit go;
    int pct;
    if (!rst) begin
      if (!in_valid || req_taken) begin
        go = 0;
        pct = (reqs_sent >= 1200 && reqs_sent < 1500) ? 0 : 9;
        if (req_queue.size() > 0) begin
          if (req_queue[0].drain_first && pending_grants.size() != 0) go = 0;
          else go = ($urandom_range(99) >= pct);
        end
        if (go) begin
          nxt = req_queue.pop_front();
          in_valid   <= 1'b1;
          req_type   <= nxt.kind;
          var_tag    <= nxt.tag;
          is_byte    <= nxt.byte_sz;
          target_reg <= nxt.code;
          reqs_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      req_taken = 0;
    end
  end

  // receiver: random stalls, one long hold-off, one quiet window
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && grants_seen >= 900) begin
        hold_done = 1;
        hold_left = 300;
        out_stall <= 1'b1;
      end else if (grants_seen >= 1200 && grants_seen < 1500) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 9);
      end
    end
  end

  // monitor: check results first, then predict for the request taken at this edge
  always @(posedge clk) begin
    grant_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        grants_seen++;
        if (pending_grants.size() == 0) begin
          report_mismatch("result with no request outstanding", int'(out_reg), 0);
        end else begin
          want = pending_grants.pop_front();
          if (out_reg != want.reg_code) begin
            report_mismatch("out_reg", int'(out_reg), int'(want.reg_code));
          end
          if (must_load != want.load) begin
            report_mismatch("must_load", int'(must_load), int'(want.load));
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_grants.push_back(predict_grant(req_t'(req_type), var_tag, is_byte,
                                               target_reg));
        reqs_accepted++;
        req_taken = 1;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_split_register_lru_allocator: FAIL");
    $finish;
  end

  initial begin
    int total;
    int r;
    int t;
    req_t kind;
    tag_t tag;
    logic [3:0] code;
    for (int s = 0; s < SLOTS; s++) begin
      slot_tag[s] = '0;
      slot_stamp[s] = '0;
    end
    lru_clock = '0;

    // directed: hits, free groups, empty tags, eviction, out-of-range codes
    add_req(REQ_REL_ALL, 16'hFFFF, 1'b1, 4'd15, 0);
    add_req(REQ_ALLOC,   16'h0001, 1'b0, 4'd0,  0);
    add_req(REQ_ALLOC,   16'h0001, 1'b0, 4'd7,  0);
    add_req(REQ_ALLOC,   16'h0002, 1'b1, 4'd0,  0);
    add_req(REQ_ALLOC,   16'h0003, 1'b1, 4'd0,  0);
    add_req(REQ_ALLOC,   16'h0000, 1'b1, 4'd0,  0);
    add_req(REQ_ALLOC,   16'h0000, 1'b0, 4'd1,  0);
    add_req(REQ_ALLOC,   16'hFFFF, 1'b0, 4'd3,  0);
    add_req(REQ_ALLOC,   16'h8000, 1'b1, 4'd9,  0);
    add_req(REQ_ALLOC,   16'h7FFF, 1'b0, 4'd0,  0);
    add_req(REQ_ALLOC,   16'h0002, 1'b1, 4'd0,  0);
    add_req(REQ_BIND,    16'h1234, 1'b0, 4'd11, 0);
    add_req(REQ_BIND,    16'h5555, 1'b1, 4'd12, 0);
    add_req(REQ_BIND,    16'hAAAA, 1'b0, 4'd15, 0);
    add_req(REQ_ALLOC,   16'h1234, 1'b1, 4'd0,  0);
    add_req(REQ_REL,     16'h0000, 1'b0, 4'd4,  0);
    add_req(REQ_REL,     16'h0000, 1'b1, 4'd13, 0);
    add_req(REQ_REL,     16'hFFFF, 1'b0, 4'd14, 0);
    add_req(REQ_ALLOC,   16'h0003, 1'b1, 4'd8,  0);
    add_req(REQ_REL_ALL, 16'h0000, 1'b0, 4'd0,  0);
    add_req(REQ_ALLOC,   16'h0000, 1'b0, 4'd2,  0);
    add_req(REQ_ALLOC,   16'h0000, 1'b1, 4'd10, 0);

    // random: a small tag pool keeps hits and evictions frequent
    for (int i = 0; i < RANDOM_REQS; i++) begin
      r = $urandom_range(99);
      if (r < 55) kind = REQ_ALLOC;
      else if (r < 70) kind = REQ_BIND;
      else if (r < 97) kind = REQ_REL;
      else kind = REQ_REL_ALL;
      t = $urandom_range(99);
      if (t < 65) tag = tag_t'($urandom_range(10, 1));
      else if (t < 75) tag = '0;
      else tag = tag_t'($urandom);
      code = ($urandom_range(99) < 85) ? 4'($urandom_range(11)) : 4'($urandom_range(15, 12));
      add_req(kind, tag, 1'($urandom_range(1)), code, i == 600);
    end
    total = req_queue.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (reqs_accepted < total || pending_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_split_register_lru_allocator: PASS");
    end else begin
      $display("tb_split_register_lru_allocator: FAIL");
    end
    $finish;
  end

endmodule
